[rtl/core/qapd_pkg.sv]
// ----------------------------------------------------------------------------
// qapd_pkg
// Shared types and constants of the quaternion attitude PD controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qapd_pkg;

   // Width of the rate inputs and the torque outputs (signed Q5.10).
   localparam int SAMPLE_WIDTH = 16;

   // Quaternion components are signed Q1.14.
   localparam int QUAT_W  = 16;
   localparam int ERR_W_W = 15;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int GAIN_W     = 16;
   localparam int LIM_W      = 16;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_ROLL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_PITCH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_YAW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_ROLL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_PITCH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_YAW   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_LIMITS  = 3'd6;

   localparam logic [CSR_DATA_W-1:0] LIMITS_RESET = 48'h2800_2800_2800;

   // Normalizer datapath widths.
   localparam int NORM_IN_W  = 32;  // signed component at scale 2^28
   localparam int NORM_MAG_W = 31;  // component magnitude
   localparam int NORM_SQ_W  = 2 * NORM_MAG_W;
   localparam int NORM_SUM_W = 64;  // sum of four squares
   localparam int ROOT_W     = NORM_SUM_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int QUO_W      = 15;  // quotient never exceeds 16384
   localparam int DIV_D_W    = ROOT_W + 1;
   localparam int DIV_NUM_W  = NORM_MAG_W + QUO_W + 1;
   localparam int DIV_CMP_W  = DIV_NUM_W + 1;

   // Request item.
   typedef struct packed {
      logic signed [QUAT_W-1:0]       meas_w;
      logic signed [QUAT_W-1:0]       meas_x;
      logic signed [QUAT_W-1:0]       meas_y;
      logic signed [QUAT_W-1:0]       meas_z;
      logic signed [QUAT_W-1:0]       want_w;
      logic signed [QUAT_W-1:0]       want_x;
      logic signed [QUAT_W-1:0]       want_y;
      logic signed [QUAT_W-1:0]       want_z;
      logic signed [SAMPLE_WIDTH-1:0] rate_roll;
      logic signed [SAMPLE_WIDTH-1:0] rate_pitch;
      logic signed [SAMPLE_WIDTH-1:0] rate_yaw;
   } req_type;

   // Result item.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] torque_roll;
      logic signed [SAMPLE_WIDTH-1:0] torque_pitch;
      logic signed [SAMPLE_WIDTH-1:0] torque_yaw;
      logic        [ERR_W_W-1:0]      err_w;
      logic signed [QUAT_W-1:0]       err_x;
      logic signed [QUAT_W-1:0]       err_y;
      logic signed [QUAT_W-1:0]       err_z;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/qapd_norm.sv]
// ----------------------------------------------------------------------------
// qapd_norm
// Pipelined quaternion normalizer: squares, a one-bit-per-stage square root
// and a one-bit-per-stage division for each component. A zero-length
// quaternion comes out as all zeros. Side data travels with each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qapd_norm #(
   parameter int NQ     = 1,
   parameter int SIDE_W = 1
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  wire                                   in_valid,
   input  wire signed [qapd_pkg::NORM_IN_W-1:0]  in_comp [NQ][4],
   input  wire        [SIDE_W-1:0]               in_side,
   output logic                                  out_valid,
   output logic signed [qapd_pkg::QUAT_W-1:0]    out_comp [NQ][4],
   output logic       [SIDE_W-1:0]               out_side
);

   localparam int MAG_W  = qapd_pkg::NORM_MAG_W;
   localparam int ROOT_W = qapd_pkg::ROOT_W;
   localparam int REM_W  = qapd_pkg::REM_W;
   localparam int SUM_W  = qapd_pkg::NORM_SUM_W;
   localparam int QUO_W  = qapd_pkg::QUO_W;
   localparam int NUM_W  = qapd_pkg::DIV_NUM_W;
   localparam int CMP_W  = qapd_pkg::DIV_CMP_W;
   localparam int D_W    = qapd_pkg::DIV_D_W;
   localparam int SQ_W   = qapd_pkg::NORM_SQ_W;

   // Data that rides along until the division stages.
   typedef struct packed {
      logic [NQ-1:0][3:0][MAG_W-1:0] mag;
      logic [NQ-1:0][3:0]            neg;
      logic [SIDE_W-1:0]             side;
   } carry_type;

   // Square stage.
   logic                  sq_vld_ff;
   carry_type             sq_car_ff;
   logic [SQ_W-1:0]       sq_val_ff [NQ][4];
   carry_type             sq_car_in;
   logic [SQ_W-1:0]       sq_val_in [NQ][4];

   always_comb begin
      sq_car_in.side = in_side;
      for (int q = 0; q < NQ; q++) begin
         for (int c = 0; c < 4; c++) begin
            sq_car_in.neg[q][c] = in_comp[q][c][qapd_pkg::NORM_IN_W-1];
            sq_car_in.mag[q][c] = in_comp[q][c][qapd_pkg::NORM_IN_W-1] ?
               MAG_W'(-in_comp[q][c]) : MAG_W'(in_comp[q][c]);
            sq_val_in[q][c] = SQ_W'(sq_car_in.mag[q][c]) * SQ_W'(sq_car_in.mag[q][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else if (en) begin
         sq_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_car_ff <= sq_car_in;
         sq_val_ff <= sq_val_in;
      end
   end

   // Pairwise sums of the squares.
   logic                  ps_vld_ff;
   carry_type             ps_car_ff;
   logic [SQ_W:0]         ps_lo_ff [NQ];
   logic [SQ_W:0]         ps_hi_ff [NQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_vld_ff <= 1'b0;
      end else if (en) begin
         ps_vld_ff <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps_car_ff <= sq_car_ff;
         for (int q = 0; q < NQ; q++) begin
            ps_lo_ff[q] <= (SQ_W+1)'(sq_val_ff[q][0]) + (SQ_W+1)'(sq_val_ff[q][1]);
            ps_hi_ff[q] <= (SQ_W+1)'(sq_val_ff[q][2]) + (SQ_W+1)'(sq_val_ff[q][3]);
         end
      end
   end

   // Square root, one root bit per stage. Index 0 holds the full sum.
   logic                  rt_vld_ff  [ROOT_W+1];
   carry_type             rt_car_ff  [ROOT_W+1];
   logic [SUM_W-1:0]      rt_rad_ff  [ROOT_W+1][NQ];
   logic [REM_W-1:0]      rt_rem_ff  [ROOT_W+1][NQ];
   logic [ROOT_W-1:0]     rt_root_ff [ROOT_W+1][NQ];

   for (genvar k = 0; k <= ROOT_W; k++) begin : g_root
      if (k == 0) begin : g_sum
         always_ff @(posedge clock) begin
            if (reset) begin
               rt_vld_ff[0] <= 1'b0;
            end else if (en) begin
               rt_vld_ff[0] <= ps_vld_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rt_car_ff[0] <= ps_car_ff;
               for (int q = 0; q < NQ; q++) begin
                  rt_rad_ff[0][q]  <= SUM_W'(ps_lo_ff[q]) + SUM_W'(ps_hi_ff[q]);
                  rt_rem_ff[0][q]  <= '0;
                  rt_root_ff[0][q] <= '0;
               end
            end
         end
      end else begin : g_step
         logic [REM_W-1:0]  rem_x [NQ];
         logic [REM_W-1:0]  trial [NQ];
         logic [REM_W-1:0]  rem_in [NQ];
         logic [ROOT_W-1:0] root_in [NQ];

         // Bring down the next two radicand bits and try a one.
         always_comb begin
            for (int q = 0; q < NQ; q++) begin
               rem_x[q] = {rt_rem_ff[k-1][q][REM_W-3:0],
                           rt_rad_ff[k-1][q][SUM_W-1-2*(k-1) -: 2]};
               trial[q] = {rt_root_ff[k-1][q], 2'b01};
               if (rem_x[q] >= trial[q]) begin
                  rem_in[q]  = rem_x[q] - trial[q];
                  root_in[q] = {rt_root_ff[k-1][q][ROOT_W-2:0], 1'b1};
               end else begin
                  rem_in[q]  = rem_x[q];
                  root_in[q] = {rt_root_ff[k-1][q][ROOT_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               rt_vld_ff[k] <= 1'b0;
            end else if (en) begin
               rt_vld_ff[k] <= rt_vld_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rt_car_ff[k]  <= rt_car_ff[k-1];
               rt_rad_ff[k]  <= rt_rad_ff[k-1];
               rt_rem_ff[k]  <= rem_in;
               rt_root_ff[k] <= root_in;
            end
         end
      end
   end

   // Division of (mag * 2^15 + r) by 2r, one quotient bit per stage.
   logic                  dv_vld_ff  [QUO_W+1];
   logic [SIDE_W-1:0]     dv_side_ff [QUO_W+1];
   logic [NQ-1:0][3:0]    dv_neg_ff  [QUO_W+1];
   logic [NQ-1:0]         dv_zero_ff [QUO_W+1];
   logic [D_W-1:0]        dv_den_ff  [QUO_W+1][NQ];
   logic [NUM_W-1:0]      dv_rem_ff  [QUO_W+1][NQ][4];
   logic [QUO_W-1:0]      dv_quo_ff  [QUO_W+1][NQ][4];

   for (genvar j = 0; j <= QUO_W; j++) begin : g_div
      if (j == 0) begin : g_setup
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[0] <= 1'b0;
            end else if (en) begin
               dv_vld_ff[0] <= rt_vld_ff[ROOT_W];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               dv_side_ff[0] <= rt_car_ff[ROOT_W].side;
               dv_neg_ff[0]  <= rt_car_ff[ROOT_W].neg;
               for (int q = 0; q < NQ; q++) begin
                  dv_zero_ff[0][q] <= (rt_root_ff[ROOT_W][q] == '0);
                  dv_den_ff[0][q]  <= {rt_root_ff[ROOT_W][q], 1'b0};
                  for (int c = 0; c < 4; c++) begin
                     dv_rem_ff[0][q][c] <=
                        NUM_W'({rt_car_ff[ROOT_W].mag[q][c], QUO_W'(0)}) +
                        NUM_W'(rt_root_ff[ROOT_W][q]);
                     dv_quo_ff[0][q][c] <= '0;
                  end
               end
            end
         end
      end else begin : g_step
         localparam int BIT = QUO_W - j;
         logic [CMP_W-1:0] shd [NQ];
         logic [NUM_W-1:0] rem_in [NQ][4];
         logic [QUO_W-1:0] quo_in [NQ][4];

         // Subtract the shifted divisor where it fits.
         always_comb begin
            for (int q = 0; q < NQ; q++) begin
               shd[q] = CMP_W'(dv_den_ff[j-1][q]) << BIT;
               for (int c = 0; c < 4; c++) begin
                  quo_in[q][c] = dv_quo_ff[j-1][q][c];
                  if (CMP_W'(dv_rem_ff[j-1][q][c]) >= shd[q]) begin
                     rem_in[q][c]      = NUM_W'(CMP_W'(dv_rem_ff[j-1][q][c]) - shd[q]);
                     quo_in[q][c][BIT] = 1'b1;
                  end else begin
                     rem_in[q][c] = dv_rem_ff[j-1][q][c];
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[j] <= 1'b0;
            end else if (en) begin
               dv_vld_ff[j] <= dv_vld_ff[j-1];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               dv_side_ff[j] <= dv_side_ff[j-1];
               dv_neg_ff[j]  <= dv_neg_ff[j-1];
               dv_zero_ff[j] <= dv_zero_ff[j-1];
               dv_den_ff[j]  <= dv_den_ff[j-1];
               dv_rem_ff[j]  <= rem_in;
               dv_quo_ff[j]  <= quo_in;
            end
         end
      end
   end

   // Apply the sign; a zero-length quaternion gives zeros.
   logic                               out_vld_ff;
   logic [SIDE_W-1:0]                  out_side_ff;
   logic signed [qapd_pkg::QUAT_W-1:0] out_comp_ff [NQ][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side_ff <= dv_side_ff[QUO_W];
         for (int q = 0; q < NQ; q++) begin
            for (int c = 0; c < 4; c++) begin
               if (dv_zero_ff[QUO_W][q]) begin
                  out_comp_ff[q][c] <= '0;
               end else if (dv_neg_ff[QUO_W][q][c]) begin
                  out_comp_ff[q][c] <= -$signed({1'b0, dv_quo_ff[QUO_W][q][c]});
               end else begin
                  out_comp_ff[q][c] <= $signed({1'b0, dv_quo_ff[QUO_W][q][c]});
               end
            end
         end
      end
   end

   assign out_valid = out_vld_ff;
   assign out_side  = out_side_ff;
   assign out_comp  = out_comp_ff;

endmodule

`default_nettype wire

[rtl/core/quaternion_attitude_pd.sv]
// ----------------------------------------------------------------------------
// quaternion_attitude_pd
// Quaternion-error PD attitude controller with per-axis torque clamp.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless a result is held at the
// output, and returns one result per item in order. Most of the pipeline
// lies in the two normalizers, each of which finds a 32-bit square root one
// bit per stage and a 15-bit quotient one bit per stage. The pipeline holds
// as a whole while a result waits on rsp_ready. Registers may be written
// while no item is in flight; they take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_attitude_pd (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire qapd_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output qapd_pkg::rsp_type                       rsp_data,
   input  wire                                     csr_we,
   input  wire  [qapd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire  [qapd_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int SW    = qapd_pkg::SAMPLE_WIDTH;
   localparam int QW    = qapd_pkg::QUAT_W;
   localparam int GW    = qapd_pkg::GAIN_W;
   localparam int LW    = qapd_pkg::LIM_W;
   localparam int IW    = qapd_pkg::NORM_IN_W;
   localparam int PM_W  = GW + QW;
   localparam int DM_W  = GW + SW;
   localparam int ACC_W = SW + 21;
   localparam int T_W   = ACC_W - 10;

   logic en;

   // Configuration registers.
   logic signed [GW-1:0]              cfg_gp_ff [3];
   logic signed [GW-1:0]              cfg_gd_ff [3];
   logic [qapd_pkg::CSR_DATA_W-1:0]   cfg_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            cfg_gp_ff[a] <= '0;
            cfg_gd_ff[a] <= '0;
         end
         cfg_lim_ff <= qapd_pkg::LIMITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            qapd_pkg::REG_GAIN_P_ROLL:  cfg_gp_ff[0] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_GAIN_P_PITCH: cfg_gp_ff[1] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_GAIN_P_YAW:   cfg_gp_ff[2] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_GAIN_D_ROLL:  cfg_gd_ff[0] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_GAIN_D_PITCH: cfg_gd_ff[1] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_GAIN_D_YAW:   cfg_gd_ff[2] <= csr_wdata[GW-1:0];
            qapd_pkg::REG_AXIS_LIMITS:  cfg_lim_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless a result is held at the output.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // First normalizer: measured and desired quaternions side by side.
   logic signed [IW-1:0]  n1_in  [2][4];
   logic signed [QW-1:0]  n1_out [2][4];
   logic [3*SW-1:0]       n1_side;
   logic                  n1_vld;

   always_comb begin
      n1_in[0][0] = {{2{req_data.meas_w[QW-1]}}, req_data.meas_w, 14'd0};
      n1_in[0][1] = {{2{req_data.meas_x[QW-1]}}, req_data.meas_x, 14'd0};
      n1_in[0][2] = {{2{req_data.meas_y[QW-1]}}, req_data.meas_y, 14'd0};
      n1_in[0][3] = {{2{req_data.meas_z[QW-1]}}, req_data.meas_z, 14'd0};
      n1_in[1][0] = {{2{req_data.want_w[QW-1]}}, req_data.want_w, 14'd0};
      n1_in[1][1] = {{2{req_data.want_x[QW-1]}}, req_data.want_x, 14'd0};
      n1_in[1][2] = {{2{req_data.want_y[QW-1]}}, req_data.want_y, 14'd0};
      n1_in[1][3] = {{2{req_data.want_z[QW-1]}}, req_data.want_z, 14'd0};
   end

   qapd_norm #(.NQ(2), .SIDE_W(3 * SW)) u_norm_in (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_ready),
      .in_comp   (n1_in),
      .in_side   ({req_data.rate_yaw, req_data.rate_pitch, req_data.rate_roll}),
      .out_valid (n1_vld),
      .out_comp  (n1_out),
      .out_side  (n1_side)
   );

   // Error quaternion conj(d) * q: products, then sums.
   logic                       ep_vld_ff;
   logic [3*SW-1:0]            ep_side_ff;
   logic signed [2*QW-1:0]     ep_prod_ff [4][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         ep_vld_ff <= 1'b0;
      end else if (en) begin
         ep_vld_ff <= n1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ep_side_ff <= n1_side;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               ep_prod_ff[i][j] <= n1_out[1][i] * n1_out[0][j];
            end
         end
      end
   end

   logic                  es_vld_ff;
   logic [3*SW-1:0]       es_side_ff;
   logic signed [IW-1:0]  es_val_ff [1][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         es_vld_ff <= 1'b0;
      end else if (en) begin
         es_vld_ff <= ep_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         es_side_ff <= ep_side_ff;
         es_val_ff[0][0] <= ep_prod_ff[0][0] + ep_prod_ff[1][1]
                          + ep_prod_ff[2][2] + ep_prod_ff[3][3];
         es_val_ff[0][1] <= ep_prod_ff[0][1] - ep_prod_ff[1][0]
                          - ep_prod_ff[2][3] + ep_prod_ff[3][2];
         es_val_ff[0][2] <= ep_prod_ff[0][2] - ep_prod_ff[2][0]
                          - ep_prod_ff[3][1] + ep_prod_ff[1][3];
         es_val_ff[0][3] <= ep_prod_ff[0][3] - ep_prod_ff[3][0]
                          - ep_prod_ff[1][2] + ep_prod_ff[2][1];
      end
   end

   // Second normalizer on the error quaternion.
   logic signed [QW-1:0]  n2_out [1][4];
   logic [3*SW-1:0]       n2_side;
   logic                  n2_vld;

   qapd_norm #(.NQ(1), .SIDE_W(3 * SW)) u_norm_err (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (es_vld_ff),
      .in_comp   (es_val_ff),
      .in_side   (es_side_ff),
      .out_valid (n2_vld),
      .out_comp  (n2_out),
      .out_side  (n2_side)
   );

   // Gain products per axis.
   logic                  am_vld_ff;
   logic signed [QW-1:0]  am_err_ff [4];
   logic signed [PM_W-1:0] am_pm_ff [3];
   logic signed [DM_W-1:0] am_dm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         am_vld_ff <= 1'b0;
      end else if (en) begin
         am_vld_ff <= n2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_err_ff <= n2_out[0];
         for (int a = 0; a < 3; a++) begin
            am_pm_ff[a] <= cfg_gp_ff[a] * n2_out[0][a+1];
            am_dm_ff[a] <= cfg_gd_ff[a] * $signed(n2_side[a*SW +: SW]);
         end
      end
   end

   // Sum of the proportional and derivative terms at scale 2^22.
   logic                    aa_vld_ff;
   logic signed [QW-1:0]    aa_err_ff [4];
   logic signed [ACC_W-1:0] aa_acc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         aa_vld_ff <= 1'b0;
      end else if (en) begin
         aa_vld_ff <= am_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aa_err_ff <= am_err_ff;
         for (int a = 0; a < 3; a++) begin
            aa_acc_ff[a] <= ACC_W'(am_pm_ff[a]) + (ACC_W'(am_dm_ff[a]) <<< 4);
         end
      end
   end

   // Round to Q5.10 with ties away from zero.
   logic                  ar_vld_ff;
   logic signed [QW-1:0]  ar_err_ff [4];
   logic signed [T_W-1:0] ar_cmd_ff [3];
   logic [ACC_W:0]        ar_mag    [3];
   logic [T_W-1:0]        ar_rnd    [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ar_mag[a] = aa_acc_ff[a][ACC_W-1] ? (ACC_W+1)'(-aa_acc_ff[a])
                                            : (ACC_W+1)'(aa_acc_ff[a]);
         ar_rnd[a] = T_W'((ar_mag[a] + (ACC_W+1)'(2048)) >> 12);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ar_vld_ff <= 1'b0;
      end else if (en) begin
         ar_vld_ff <= aa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ar_err_ff <= aa_err_ff;
         for (int a = 0; a < 3; a++) begin
            ar_cmd_ff[a] <= aa_acc_ff[a][ACC_W-1] ? -$signed(ar_rnd[a])
                                                   : $signed(ar_rnd[a]);
         end
      end
   end

   // Clamp each axis to its limit, itself capped at the largest torque code.
   localparam logic [T_W-1:0] TORQUE_TOP = T_W'((64'd1 << (SW - 1)) - 64'd1);

   logic signed [T_W-1:0] lim [3];
   logic signed [T_W-1:0] clamped [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lim[a] = (T_W'(cfg_lim_ff[a*LW +: LW]) > TORQUE_TOP) ?
                  $signed(TORQUE_TOP) : $signed(T_W'(cfg_lim_ff[a*LW +: LW]));
         priority if (ar_cmd_ff[a] >= lim[a]) begin
            clamped[a] = lim[a];
         end else if (ar_cmd_ff[a] <= -lim[a]) begin
            clamped[a] = -lim[a];
         end else begin
            clamped[a] = ar_cmd_ff[a];
         end
      end
   end

   // Output register.
   logic               out_vld_ff;
   qapd_pkg::rsp_type  out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= ar_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff.torque_roll  <= clamped[0][SW-1:0];
         out_data_ff.torque_pitch <= clamped[1][SW-1:0];
         out_data_ff.torque_yaw   <= clamped[2][SW-1:0];
         out_data_ff.err_w        <= ar_err_ff[0][QW-1] ? qapd_pkg::ERR_W_W'(-ar_err_ff[0])
                                                        : qapd_pkg::ERR_W_W'(ar_err_ff[0]);
         out_data_ff.err_x        <= ar_err_ff[1];
         out_data_ff.err_y        <= ar_err_ff[2];
         out_data_ff.err_z        <= ar_err_ff[3];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // The normalized error never exceeds one in its w or x component.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.err_w <= 15'd16384))
      else $error("err_w above one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.err_x <= 16'sd16384 && rsp_data.err_x >= -16'sd16384))
      else $error("err_x out of range");

   // A roll command lies within its limit while the stage feeding the output clamps it.
   assert property (@(posedge clock) disable iff (reset)
      (ar_vld_ff && en) |-> (clamped[0] <= lim[0] && clamped[0] >= -lim[0]))
      else $error("roll torque outside its limit");
`endif

endmodule

`default_nettype wire
